>>> src/bsmg_pkg.sv
package bsmg_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = 11;
   localparam int DATA_W   = 32;
   localparam int STEP_W   = 3;

   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE  = 3'd0;
   localparam step_type STEP_CHECK = 3'd1;
   localparam step_type STEP_READ  = 3'd2;
   localparam step_type STEP_CMP   = 3'd3;
   localparam step_type STEP_FULL  = 3'd4;
   localparam step_type STEP_STORE = 3'd5;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_TOO_FEW = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      COND_NONE      = 3'd0,
      COND_NO_REQ    = 3'd1,
      COND_FULL      = 3'd2,
      COND_SCAN_DONE = 3'd3,
      COND_OUT_BUSY  = 3'd4
   } cond_type;

   localparam logic REG_MAX_COUNT = 1'b0;

   typedef struct packed {
      logic accept;
      logic read;
      logic cmp;
      logic emit_full;
      logic store;
   } act_type;

   typedef struct packed {
      cond_type cond;
      step_type on_true;
      step_type on_false;
      logic     hold;
      act_type  act;
   } uword_type;

   typedef struct packed {
      act_type act;
      logic    fire;
   } ctl_type;

   typedef struct packed {
      logic no_req;
      logic full;
      logic scan_done;
      logic out_busy;
   } flags_type;

   // control store
   function automatic uword_type urom(step_type s);
      uword_type w;
      w = '0;
      case (s)
         STEP_IDLE: begin
            w.cond = COND_NO_REQ;    w.on_true = STEP_IDLE;  w.on_false = STEP_CHECK;
            w.hold = 1'b1;           w.act.accept = 1'b1;
         end
         STEP_CHECK: begin
            w.cond = COND_FULL;      w.on_true = STEP_FULL;  w.on_false = STEP_READ;
         end
         STEP_READ: begin
            w.cond = COND_SCAN_DONE; w.on_true = STEP_STORE; w.on_false = STEP_CMP;
            w.act.read = 1'b1;
         end
         STEP_CMP: begin
            w.cond = COND_NONE;      w.on_true = STEP_READ;  w.on_false = STEP_READ;
            w.act.cmp = 1'b1;
         end
         STEP_FULL: begin
            w.cond = COND_OUT_BUSY;  w.on_true = STEP_FULL;  w.on_false = STEP_IDLE;
            w.hold = 1'b1;           w.act.emit_full = 1'b1;
         end
         STEP_STORE: begin
            w.cond = COND_OUT_BUSY;  w.on_true = STEP_STORE; w.on_false = STEP_IDLE;
            w.hold = 1'b1;           w.act.store = 1'b1;
         end
         default: begin
            w.cond = COND_NONE;      w.on_true = STEP_IDLE;  w.on_false = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

>>> src/bsmg_ram.sv
module bsmg_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/bsmg_sequencer.sv
module bsmg_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  bsmg_pkg::flags_type flags,
   output bsmg_pkg::ctl_type   ctl
);

   bsmg_pkg::step_type  pc_ff, pc_in;
   bsmg_pkg::uword_type word;
   logic                taken;

   assign word = bsmg_pkg::urom(pc_ff);

   always_comb begin
      case (word.cond)
         bsmg_pkg::COND_NONE:      taken = 1'b0;
         bsmg_pkg::COND_NO_REQ:    taken = flags.no_req;
         bsmg_pkg::COND_FULL:      taken = flags.full;
         bsmg_pkg::COND_SCAN_DONE: taken = flags.scan_done;
         bsmg_pkg::COND_OUT_BUSY:  taken = flags.out_busy;
         default:                  taken = 1'b0;
      endcase
      pc_in    = taken ? word.on_true : word.on_false;
      ctl.act  = word.act;
      ctl.fire = !(taken && word.hold);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= bsmg_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

>>> src/bsmg_datapath.sv
module bsmg_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  bsmg_pkg::ctl_type                 ctl,
   input  logic [bsmg_pkg::COUNT_W-1:0]      limit,
   output bsmg_pkg::flags_type               flags,
   output logic [bsmg_pkg::COUNT_W-1:0]      stored,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [79:0]                       rsp_tdata
);

   localparam int DW = bsmg_pkg::DATA_W;
   localparam int CW = bsmg_pkg::COUNT_W;
   localparam int AW = bsmg_pkg::ADDR_W;

   logic [DW-1:0] v_ff, v_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [DW-1:0] min_ff, min_in, max_ff, max_in, gap_ff, gap_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   bsmg_pkg::status_type status_ff, status_in;
   logic [DW-1:0]        short_ff, short_in, long_ff, long_in;
   logic [CW-1:0]        rcount_ff, rcount_in;

   logic          do_accept, do_read, do_cmp, do_full, do_store;
   logic [DW-1:0] rdata, span_now;
   logic          v_below;

   assign do_accept = ctl.act.accept && ctl.fire;
   assign do_read   = ctl.act.read && ctl.fire;
   assign do_cmp    = ctl.act.cmp && ctl.fire;
   assign do_full   = ctl.act.emit_full && ctl.fire;
   assign do_store  = ctl.act.store && ctl.fire;

   bsmg_ram #(.DEPTH(bsmg_pkg::CAPACITY), .WIDTH(DW)) u_store (
      .clock (clock),
      .we    (do_store),
      .waddr (count_ff[AW-1:0]),
      .wdata (v_ff),
      .re    (do_read),
      .raddr (idx_ff[AW-1:0]),
      .rdata (rdata)
   );

   assign v_below  = $signed(v_ff) < $signed(rdata);
   assign span_now = v_below ? (rdata - v_ff) : (v_ff - rdata);

   always_comb begin
      v_in         = v_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      gap_in       = gap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      short_in     = short_ff;
      long_in      = long_ff;
      rcount_in    = rcount_ff;

      if (do_accept) begin
         v_in   = req_tdata;
         idx_in = '0;
         if (req_tuser[0]) begin
            count_in = '0;
            min_in   = '0;
            max_in   = '0;
            gap_in   = '1;
         end
      end

      if (do_cmp) begin
         idx_in = idx_ff + 1'b1;
         if (span_now < gap_ff) begin
            gap_in = span_now;
         end
      end

      if (do_full) begin
         rsp_valid_in = 1'b1;
         status_in    = bsmg_pkg::ST_FULL;
         short_in     = '0;
         long_in      = '0;
         rcount_in    = count_ff;
      end

      if (do_store) begin
         if (count_ff == '0 || $signed(v_ff) < $signed(min_ff)) begin
            min_in = v_ff;
         end
         if (count_ff == '0 || $signed(max_ff) < $signed(v_ff)) begin
            max_in = v_ff;
         end
         count_in     = count_ff + 1'b1;
         rsp_valid_in = 1'b1;
         rcount_in    = count_in;
         if (count_in < CW'(2)) begin
            status_in = bsmg_pkg::ST_TOO_FEW;
            short_in  = '0;
            long_in   = '0;
         end else begin
            status_in = bsmg_pkg::ST_OK;
            short_in  = gap_ff;
            long_in   = max_in - min_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         gap_ff       <= '1;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         gap_ff       <= gap_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff      <= v_in;
      status_ff <= status_in;
      short_ff  <= short_in;
      long_ff   <= long_in;
      rcount_ff <= rcount_in;
   end

   assign flags.no_req    = !req_tvalid;
   assign flags.full      = count_ff >= limit;
   assign flags.scan_done = idx_ff == count_ff;
   assign flags.out_busy  = rsp_valid_ff && !rsp_tready;

   assign stored     = count_ff;
   assign req_tready = ctl.act.accept;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b0, rcount_ff, long_ff, short_ff, status_ff};

endmodule

>>> src/bounded_set_min_gap_and_range.sv
// Set of up to max_count signed 32-bit words (store of 1024 entries). Each request word is
// compared, unless the store is full, against every stored entry by a small microcoded
// sequencer through a single-port-read memory: steps accept, full check, then one store read
// and one compare per entry, a final read and store; a refused add goes from the full check
// to a full result. One word is processed at a time; the next request is taken while the
// previous result still waits in the output register. start_new (tuser bit 0) empties the
// set before the value is added. Status: 0 ok, 1 fewer than two values, 2 full/refused.
module bounded_set_min_gap_and_range (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [0:0]  req_tuser,   // [0] start_new
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [1:0] status, [33:2] shortest_span,
                                    // [65:34] longest_span, [76:66] stored_count
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW = bsmg_pkg::COUNT_W;

   logic [CW-1:0] max_count_ff, limit, stored;
   logic          csr_wr;

   bsmg_pkg::flags_type flags;
   bsmg_pkg::ctl_type   ctl;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_count_ff <= bsmg_pkg::CAP_COUNT;
      end else if (csr_wr && csr_paddr[2] == bsmg_pkg::REG_MAX_COUNT) begin
         max_count_ff <= csr_pwdata[CW-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == bsmg_pkg::REG_MAX_COUNT) ?
                       {{(32-CW){1'b0}}, max_count_ff} : 32'd0;

   assign limit = (max_count_ff > bsmg_pkg::CAP_COUNT) ? bsmg_pkg::CAP_COUNT : max_count_ff;

   bsmg_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   bsmg_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .limit      (limit),
      .flags      (flags),
      .stored     (stored),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_ok_needs_two: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == bsmg_pkg::ST_OK) |-> rsp_tdata[76:66] >= CW'(2))
      else $error("ok result with fewer than two stored words");

   a_full_zero_spans: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != bsmg_pkg::ST_OK) |-> rsp_tdata[65:2] == '0)
      else $error("nonzero span on non-ok result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stored <= bsmg_pkg::CAP_COUNT)
      else $error("stored count above capacity");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous word still in work");

endmodule

>>> tb/bounded_set_min_gap_and_range_test.sv
module bounded_set_min_gap_and_range_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [31:0] value;
      logic        start_new;
   } add_word_type;

   typedef struct {
      bsmg_pkg::status_type status;
      logic [31:0]          shortest;
      logic [31:0]          longest;
      logic [10:0]          count;
   } span_report_type;

   localparam logic [2:0] MAX_COUNT_ADDR = {bsmg_pkg::REG_MAX_COUNT, 2'b00};
   localparam logic [10:0] PHASE_LIMITS [9] = '{11'd8, 11'd1024, 11'd3, 11'd2047, 11'd17,
                                                11'd1, 11'd1024, 11'd600, 11'd1100};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value
   logic [0:0]  req_tuser = '0;   // [0] start_new
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // [1:0] status, [33:2] shortest_span,
                                  // [65:34] longest_span, [76:66] stored_count
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   add_word_type    pending_adds [$];
   span_report_type expected_reports [$];
   int              mismatch_count = 0;
   int              send_idle_pct = 19;
   int              recv_idle_pct = 57;
   int              phase_index = -1;
   logic            req_taken = 1'b0;
   logic            hold_off = 1'b0;

   // set model
   logic [31:0]        model_set [bsmg_pkg::CAPACITY];
   int                 model_count = 0;
   logic signed [31:0] model_lo = '0;
   logic signed [31:0] model_hi = '0;
   logic [31:0]        model_gap = '1;
   logic [10:0]        model_max_count = bsmg_pkg::CAP_COUNT;

   bounded_set_min_gap_and_range dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic span_report_type predict_add(logic [31:0] v, logic start_new);
      span_report_type r;
      logic [31:0] d;
      int limit;
      limit = (model_max_count > bsmg_pkg::CAPACITY) ? bsmg_pkg::CAPACITY : model_max_count;
      r.shortest = '0;
      r.longest = '0;
      if (start_new) begin
         model_count = 0;
         model_lo = '0;
         model_hi = '0;
         model_gap = '1;
      end
      if (model_count >= limit) begin
         r.status = bsmg_pkg::ST_FULL;
      end else begin
         for (int i = 0; i < model_count; i++) begin
            d = ($signed(v) < $signed(model_set[i])) ? model_set[i] - v : v - model_set[i];
            if (d < model_gap) model_gap = d;
         end
         if (model_count == 0) begin
            model_lo = v;
            model_hi = v;
         end else begin
            if ($signed(v) < model_lo) model_lo = v;
            if (model_hi < $signed(v)) model_hi = v;
         end
         model_set[model_count] = v;
         model_count++;
         if (model_count < 2) begin
            r.status = bsmg_pkg::ST_TOO_FEW;
         end else begin
            r.status = bsmg_pkg::ST_OK;
            r.shortest = model_gap;
            r.longest = model_hi - model_lo;
         end
      end
      r.count = 11'(model_count);
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
   endtask

   task automatic queue_add(logic [31:0] v, logic start_new);
      add_word_type w;
      w.value = v;
      w.start_new = start_new;
      pending_adds = {pending_adds, w};
   endtask

   task automatic drain();
      while (pending_adds.size() > 0 || req_tvalid || expected_reports.size() > 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_max_count(logic [10:0] limit);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= MAX_COUNT_ADDR;
      csr_pwdata <= {21'($urandom), limit};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      model_max_count = limit;
      @(negedge clock);
      csr_psel <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      check_field("max_count readback", 32'(limit), csr_prdata);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin : drive_adds
      add_word_type next_add;
      if (!req_tvalid || req_taken) begin
         if (!reset && pending_adds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_add = pending_adds.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= next_add.value;
            req_tuser <= next_add.start_new;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // result receiver
   always @(negedge clock) begin
      if (hold_off) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // long output stall while the sender keeps going
   initial begin
      wait (phase_index == 1);
      repeat (20) @(posedge clock);
      hold_off = 1'b1;
      repeat (300) @(posedge clock);
      hold_off = 1'b0;
   end

   // monitor: predict on accepted request word, check on accepted result word
   always @(posedge clock) begin : watch_words
      span_report_type want;
      span_report_type next_report;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            next_report = predict_add(req_tdata, req_tuser[0]);
            expected_reports = {expected_reports, next_report};
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result word with nothing expected: %h", rsp_tdata);
            end else begin
               want = expected_reports.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_tdata[1:0]));
               check_field("shortest_span", want.shortest, rsp_tdata[33:2]);
               check_field("longest_span", want.longest, rsp_tdata[65:34]);
               check_field("stored_count", 32'(want.count), 32'(rsp_tdata[76:66]));
            end
         end
      end
   end

   initial begin
      int queued;
      int set_size;
      logic [31:0] base;
      logic [31:0] v;
      logic fresh;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset limit of 1024
      queue_add(32'h0000_0000, 1'b1);
      queue_add(32'h7FFF_FFFF, 1'b0);
      queue_add(32'h8000_0000, 1'b0);
      queue_add(32'h0000_0000, 1'b0);
      queue_add(32'hFFFF_FFFF, 1'b0);
      queue_add(32'h8000_0000, 1'b1);
      queue_add(32'h7FFF_FFFF, 1'b0);
      queue_add(32'h1234_5678, 1'b1);
      queue_add(32'h1234_5679, 1'b0);
      queue_add(32'hFFFF_FFFF, 1'b1);
      queue_add(32'h0000_0001, 1'b0);
      drain();
      // limit zero refuses everything
      set_max_count(11'd0);
      queue_add(32'h0000_0005, 1'b1);
      queue_add(32'hAAAA_AAAA, 1'b0);
      drain();
      // limit above capacity
      set_max_count(11'd2047);
      queue_add(32'h5555_5555, 1'b1);
      queue_add(32'h0000_0000, 1'b0);
      queue_add(32'h0000_0001, 1'b0);
      drain();
      set_max_count(11'd2);
      queue_add(32'd7, 1'b1);
      queue_add(32'd9, 1'b0);
      queue_add(32'd11, 1'b0);
      queue_add(32'd11, 1'b1);
      drain();
      // full wins over too few
      set_max_count(11'd1);
      queue_add(32'd3, 1'b1);
      queue_add(32'd4, 1'b0);

      for (int p = 0; p < 9; p++) begin
         drain();
         phase_index = p;
         send_idle_pct = (p < 3) ? 19 : (p < 6) ? 57 : 0;
         recv_idle_pct = (p < 3) ? 57 : (p < 6) ? 19 : 0;
         set_max_count(PHASE_LIMITS[p]);
         queued = 0;
         while (queued < 48) begin
            if (p == 6 && queued == 0) begin
               set_size = 150;
            end else begin
               case ($urandom_range(9))
                  0, 1, 2, 3, 4, 5: set_size = $urandom_range(1, 6);
                  6, 7, 8:          set_size = $urandom_range(7, 20);
                  default:          set_size = $urandom_range(21, 45);
               endcase
            end
            fresh = ($urandom_range(9) != 0);
            base = $urandom;
            for (int k = 0; k < set_size; k++) begin
               case ($urandom_range(9))
                  0, 1, 2, 3: v = $urandom;
                  4, 5, 6:    v = base + $urandom_range(0, 63) - 32;
                  7:          v = base ^ (32'h1 << $urandom_range(31));
                  8: begin
                     case ($urandom_range(3))
                        0:       v = 32'h8000_0000;
                        1:       v = 32'h7FFF_FFFF;
                        2:       v = 32'h0000_0000;
                        default: v = 32'hFFFF_FFFF;
                     endcase
                  end
                  default:    v = base;
               endcase
               queue_add(v, (k == 0 && fresh) || ($urandom_range(39) == 0));
               queued++;
            end
         end
      end

      drain();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
